[hdl/cas_pkg.sv]
// Shared constants, types and helper functions for the contrast adaptive sharpener.
// Used by cas_chan and the top level; depends on nothing.
package cas_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIX_W     = FRAC_BITS + 1;
  localparam int SUM_W     = FIX_W + 2;
  localparam int NUM_W     = 2 * FRAC_BITS + 1;
  localparam int DEN_W     = FIX_W + 2;
  localparam int DIV_QW    = FIX_W;
  localparam int T_W       = 25;
  localparam int FDIV_QW   = 11;
  localparam int MAG_W     = 14;
  localparam int SCALE_W   = 17;
  localparam int CHAN_LAT  = 3 + DIV_QW + 4 + FDIV_QW + 1;

  localparam logic [FIX_W-1:0]   ONE          = FIX_W'(1) << FRAC_BITS;
  localparam logic [FIX_W-1:0]   LOBE_LIMIT   = FIX_W'((3 << FRAC_BITS) >> 4);
  localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(16384);
  localparam logic [SCALE_W-1:0] SCALE_MAX    = SCALE_W'(65536);
  localparam logic               REG_LOBE_SCALE = 1'b0;

  typedef struct packed {
    logic [FIX_W-1:0] e;
    logic [SUM_W-1:0] sum4;
    logic             gt1;
  } side_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        border;
  } ctr_t;

  // Maps an 8-bit channel value onto the 16-fraction-bit scale, rounded to nearest.
  function automatic logic [FIX_W-1:0] to_fixed(input logic [7:0] c);
    to_fixed = {1'b0, c, 8'b0} + {9'b0, c} + {16'b0, c[7]};
  endfunction

endpackage

[hdl/cas_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the quotient must fit in QUO_W bits.
module cas_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 19,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo
);
  localparam int SW = DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [QUO_W-1:0] vld_r;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             vld_in;
    logic [SW-1:0]    dsh;
    logic [SW-1:0]    rext;
    logic             take;
    logic [NUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    always_comb begin
      dsh     = SW'(den_in) << (QUO_W - 1 - k);
      rext    = SW'(rem_in);
      take    = (rext >= dsh);
      rem_nxt = take ? NUM_W'(rext - dsh) : rem_in;
      quo_nxt = take ? (quo_in | (QUO_W'(1) << (QUO_W - 1 - k))) : quo_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_in;
      quo_r[k] <= quo_nxt;
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign quo       = quo_r[QUO_W-1];
endmodule

[hdl/cas_chan.sv]
// Sharpening datapath for one color channel: local range, lobe, damping and blend.
// Depends on cas_pkg and cas_div.
module cas_chan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [7:0]                  ce,
  input  logic [7:0]                  cb,
  input  logic [7:0]                  cd,
  input  logic [7:0]                  cf,
  input  logic [7:0]                  ch,
  input  logic [cas_pkg::SCALE_W-1:0] scale,
  output logic                        out_valid,
  output logic [7:0]                  out_byte
);
  import cas_pkg::*;

  // Stage 1: fixed-point conversion.
  logic             v1_r;
  logic [FIX_W-1:0] e1_r, b1_r, d1_r, f1_r, h1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    e1_r <= to_fixed(ce);
    b1_r <= to_fixed(cb);
    d1_r <= to_fixed(cd);
    f1_r <= to_fixed(cf);
    h1_r <= to_fixed(ch);
  end

  // Stage 2: minimum, maximum and neighbor sum.
  logic             v2_r;
  logic [FIX_W-1:0] e2_r, mn2_r, mx2_r, mn_nxt, mx_nxt;
  logic [SUM_W-1:0] sum2_r;

  always_comb begin
    mn_nxt = e1_r;
    mx_nxt = e1_r;
    if (b1_r < mn_nxt) mn_nxt = b1_r;
    if (d1_r < mn_nxt) mn_nxt = d1_r;
    if (f1_r < mn_nxt) mn_nxt = f1_r;
    if (h1_r < mn_nxt) mn_nxt = h1_r;
    if (b1_r > mx_nxt) mx_nxt = b1_r;
    if (d1_r > mx_nxt) mx_nxt = d1_r;
    if (f1_r > mx_nxt) mx_nxt = f1_r;
    if (h1_r > mx_nxt) mx_nxt = h1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    e2_r   <= e1_r;
    mn2_r  <= mn_nxt;
    mx2_r  <= mx_nxt;
    sum2_r <= SUM_W'(b1_r) + SUM_W'(d1_r) + SUM_W'(f1_r) + SUM_W'(h1_r);
  end

  // Stage 3: dividend and divisor setup for the three quotients.
  logic             v3_r;
  logic [NUM_W-1:0] hmin_num_r, hmax_num_r, nz_num_r;
  logic [DEN_W-1:0] hmin_den_r, hmax_den_r, nz_den_r;
  side_t            side3_r;
  logic [FIX_W-1:0] rng;
  logic [SUM_W:0]   sdiff;
  logic [SUM_W-1:0] adiff;

  always_comb begin
    rng   = mx2_r - mn2_r;
    sdiff = {1'b0, sum2_r} - {1'b0, e2_r, 2'b0};
    adiff = sdiff[SUM_W] ? SUM_W'(-sdiff) : sdiff[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    hmin_num_r   <= {mn2_r, FRAC_BITS'(0)};
    hmin_den_r   <= {mx2_r, 2'b01};
    hmax_num_r   <= {FIX_W'(ONE - mx2_r), FRAC_BITS'(0)};
    hmax_den_r   <= {FIX_W'(ONE - mn2_r), 2'b01};
    nz_num_r     <= {adiff, (FRAC_BITS - 2)'(0)};
    nz_den_r     <= DEN_W'(rng);
    side3_r.e    <= e2_r;
    side3_r.sum4 <= sum2_r;
    side3_r.gt1  <= (rng > FIX_W'(1));
  end

  // Three dividers in parallel; the side data rides a matching delay line.
  logic              dv_hmin, dv_hmax, dv_nz;
  logic [DIV_QW-1:0] q_hmin, q_hmax, q_nz;
  side_t             side_r [DIV_QW];

  cas_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(DIV_QW)) u_div_hmin (
    .clk(clk), .rst_n(rst_n), .in_valid(v3_r), .num(hmin_num_r), .den(hmin_den_r),
    .out_valid(dv_hmin), .quo(q_hmin)
  );
  cas_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(DIV_QW)) u_div_hmax (
    .clk(clk), .rst_n(rst_n), .in_valid(v3_r), .num(hmax_num_r), .den(hmax_den_r),
    .out_valid(dv_hmax), .quo(q_hmax)
  );
  cas_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(DIV_QW)) u_div_nz (
    .clk(clk), .rst_n(rst_n), .in_valid(v3_r), .num(nz_num_r), .den(nz_den_r),
    .out_valid(dv_nz), .quo(q_nz)
  );

  always_ff @(posedge clk) begin
    side_r[0] <= side3_r;
    for (int i = 1; i < DIV_QW; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Stage 4: clamp the lobe and apply the sharpness scale.
  logic              v4_r;
  logic [MAG_W-1:0]  mag4_r;
  logic [DIV_QW-1:0] nzq4_r;
  side_t             side4_r;
  logic [DIV_QW-1:0] m0;
  logic [MAG_W+SCALE_W-1:0] sprod;

  always_comb begin
    m0 = q_hmin;
    if (q_hmax < m0) m0 = q_hmax;
    if (LOBE_LIMIT < m0) m0 = LOBE_LIMIT;
    sprod = m0[MAG_W-1:0] * scale;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= dv_hmin & dv_hmax & dv_nz;
    end
    mag4_r  <= sprod[FRAC_BITS +: MAG_W];
    nzq4_r  <= q_nz;
    side4_r <= side_r[DIV_QW-1];
  end

  // Stage 5: noise damping.
  logic             v5_r;
  logic [MAG_W-1:0] mag5_r;
  side_t            side5_r;
  logic [FIX_W-1:0] fac;
  logic [MAG_W+FIX_W-1:0] dprod;

  always_comb begin
    fac   = ONE - {1'b0, nzq4_r[DIV_QW-1:1]};
    dprod = mag4_r * fac;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    mag5_r  <= side4_r.gt1 ? dprod[FRAC_BITS +: MAG_W] : mag4_r;
    side5_r <= side4_r;
  end

  // Stage 6: blend numerator and denominator.
  logic              v6_r;
  logic [NUM_W:0]    num6_r;
  logic [FIX_W-1:0]  den6_r;
  logic [NUM_W-1:0]  lprod;

  assign lprod = NUM_W'(mag5_r) * NUM_W'(side5_r.sum4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    num6_r <= {1'b0, side5_r.e, FRAC_BITS'(0)} - {1'b0, lprod};
    den6_r <= ONE - {1'b0, mag5_r, 2'b0};
  end

  // Stage 7: scale to 0..255 before the final division.
  logic             v7_r;
  logic [T_W-1:0]   t7_r;
  logic [FIX_W-1:0] den7_r;
  logic [NUM_W+7:0] tprod;
  logic             pos;

  always_comb begin
    pos   = !num6_r[NUM_W] && (num6_r != '0);
    tprod = {num6_r[NUM_W-1:0], 8'b0} - {8'b0, num6_r[NUM_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    t7_r   <= pos ? tprod[FRAC_BITS +: T_W] : '0;
    den7_r <= den6_r;
  end

  logic               fv;
  logic [FDIV_QW-1:0] fq;

  cas_div #(.NUM_W(T_W), .DEN_W(FIX_W), .QUO_W(FDIV_QW)) u_div_out (
    .clk(clk), .rst_n(rst_n), .in_valid(v7_r), .num(t7_r), .den(den7_r),
    .out_valid(fv), .quo(fq)
  );

  logic       vo_r;
  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= fv;
    end
    byte_r <= (fq[FDIV_QW-1:8] != '0) ? 8'hFF : fq[7:0];
  end

  assign out_valid = vo_r;
  assign out_byte  = byte_r;
endmodule

[hdl/contrast_adaptive_sharpen_top.sv]
// Contrast adaptive sharpener, top level: register port, input beat, three channel
// datapaths and the output register. Depends on cas_pkg and cas_chan.
//
// A pixel beat is taken in every cycle that start is high and busy is low; busy is
// high only during reset and the cycle after it. Each beat returns one out_pixel
// with out_valid high for one cycle, in the order the beats were taken.
// Most of the pipeline is the two chains of one-bit-per-stage dividers in each channel
// datapath (17 stages for the lobe limits and noise ratio, 11 for the final blend).
module contrast_adaptive_sharpen_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_center_pixel,
  input  logic [31:0] in_up_pixel,
  input  logic [31:0] in_left_pixel,
  input  logic [31:0] in_right_pixel,
  input  logic [31:0] in_down_pixel,
  input  logic        in_on_border,
  output logic        out_valid,
  output logic [31:0] out_pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cas_pkg::*;

  logic               busy_r;
  logic [SCALE_W-1:0] scale_r;
  logic [SCALE_W-1:0] scale_sat;
  logic               fire;

  assign pready    = 1'b1;
  assign busy      = busy_r;
  assign fire      = start && !busy_r;
  assign prdata    = (paddr[2] == REG_LOBE_SCALE) ? {(32 - SCALE_W)'(0), scale_r} : 32'd0;
  assign scale_sat = (scale_r > SCALE_MAX) ? SCALE_MAX : scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      scale_r <= SCALE_RESET;
    end else begin
      busy_r <= 1'b0;
      if (psel && penable && pwrite && pready && (paddr[2] == REG_LOBE_SCALE)) begin
        scale_r <= pwdata[SCALE_W-1:0];
      end
    end
  end

  logic [2:0] cv;
  logic [7:0] cbyte [3];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    cas_chan u_chan (
      .clk(clk), .rst_n(rst_n), .in_valid(fire),
      .ce(in_center_pixel[8*k +: 8]), .cb(in_up_pixel[8*k +: 8]),
      .cd(in_left_pixel[8*k +: 8]), .cf(in_right_pixel[8*k +: 8]),
      .ch(in_down_pixel[8*k +: 8]), .scale(scale_sat),
      .out_valid(cv[k]), .out_byte(cbyte[k])
    );
  end

  ctr_t ctr_r [CHAN_LAT];

  always_ff @(posedge clk) begin
    ctr_r[0].pixel  <= in_center_pixel;
    ctr_r[0].border <= in_on_border;
    for (int i = 1; i < CHAN_LAT; i++) begin
      ctr_r[i] <= ctr_r[i-1];
    end
  end

  logic        out_valid_r;
  logic [31:0] out_pixel_r, out_pixel_nxt;

  always_comb begin
    if (ctr_r[CHAN_LAT-1].border) begin
      out_pixel_nxt = ctr_r[CHAN_LAT-1].pixel;
    end else begin
      out_pixel_nxt = {ctr_r[CHAN_LAT-1].pixel[31:24], cbyte[2], cbyte[1], cbyte[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cv[0];
    end
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(fire, CHAN_LAT + 1))
    else $error("result beat does not match an accepted beat");

  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    cv[0] |-> (cv[1] && cv[2]))
    else $error("channel datapaths out of step");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel[31:24] == $past(in_center_pixel[31:24], CHAN_LAT + 1))
    else $error("alpha not carried from center pixel");

  a_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_on_border, CHAN_LAT + 1))
      |-> out_pixel == $past(in_center_pixel, CHAN_LAT + 1))
    else $error("border pixel altered");
endmodule
